[rtl/core/pal_pkg.sv]
// Shared types and constants for the positional array list block.
// Used by pal_ctrl, pal_dpath and positional_array_list; no dependencies.
package pal_pkg;

   // Store geometry
   localparam int DEPTH   = 16;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int DATA_W  = 32;
   localparam int POS_W   = 8;
   localparam int OP_W    = 2;
   localparam int ST_W    = 2;
   localparam int CAP_W   = 5;

   // Configuration port
   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;
   localparam logic [0:0] REG_CAPACITY = 1'b0;
   localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(16);

   // Opcodes
   localparam logic [OP_W-1:0] OP_READ    = 2'd0;
   localparam logic [OP_W-1:0] OP_REPLACE = 2'd1;
   localparam logic [OP_W-1:0] OP_INSERT  = 2'd2;
   localparam logic [OP_W-1:0] OP_DELETE  = 2'd3;

   // Status codes
   localparam logic [ST_W-1:0] ST_DONE   = 2'd0;
   localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
   localparam logic [ST_W-1:0] ST_EMPTY  = 2'd2;
   localparam logic [ST_W-1:0] ST_BADPOS = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]          opcode;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic                     ok;
      logic [ST_W-1:0]          status;
      logic signed [DATA_W-1:0] read_value;
      logic [CNT_W-1:0]         count;
      logic                     empty_flag;
      logic                     full_flag;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;
      logic exec;
   } ctrl_cmd_type;

endpackage

[rtl/core/pal_ctrl.sv]
// Transaction controller for the positional array list.
// Depends on pal_pkg; drives pal_dpath through ctrl_cmd_type.
module pal_ctrl
   import pal_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   output ctrl_cmd_type cmd,
   output logic         rsp_strobe
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic state_ff, state_in;
   logic strobe_ff, strobe_in;

   // Accept in idle, then execute and return to idle
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy      = (state_ff == S_EXEC);
   assign cmd.load  = start && !busy;
   assign cmd.exec  = (state_ff == S_EXEC);
   assign strobe_in = cmd.exec;

   // Advance state and mark the result cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign rsp_strobe = strobe_ff;

endmodule

[rtl/core/pal_dpath.sv]
// Datapath of the positional array list: request latch, element cells,
// element count and result register. Depends on pal_pkg.
module pal_dpath
   import pal_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  ctrl_cmd_type     cmd,
   input  req_type          req_payload,
   input  logic [CNT_W-1:0] cap_use,
   output rsp_type          rsp_payload
);

   req_type           req_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   rsp_type           rsp_ff, rsp_in;
   logic [DATA_W-1:0] store_ff [DEPTH];
   logic [DATA_W-1:0] store_in [DEPTH];

   logic [POS_W:0]    pos9, cnt9, p0;
   logic              pos_nz, in_rng, ins_rng, full_now;
   logic              do_ins, do_del, do_rep;
   logic [ST_W-1:0]   status;
   logic [DATA_W-1:0] rd;

   // Hold the request while it executes
   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_payload;
   end

   // Position checks against the current length
   assign pos9     = {1'b0, req_ff.position};
   assign cnt9     = (POS_W + 1)'(count_ff);
   assign p0       = pos9 - (POS_W + 1)'(1);
   assign pos_nz   = (req_ff.position != '0);
   assign in_rng   = pos_nz && (pos9 <= cnt9);
   assign ins_rng  = pos_nz && (pos9 <= cnt9 + (POS_W + 1)'(1));
   assign full_now = (count_ff >= cap_use);

   // Decide the outcome of the operation
   always_comb begin
      status   = ST_DONE;
      rd       = '0;
      do_ins   = 1'b0;
      do_del   = 1'b0;
      do_rep   = 1'b0;
      count_in = count_ff;
      case (req_ff.opcode)
         OP_READ: begin
            if (in_rng) rd = store_ff[p0[IDX_W-1:0]];
            else        status = ST_BADPOS;
         end
         OP_REPLACE: begin
            if (in_rng) do_rep = 1'b1;
            else        status = ST_BADPOS;
         end
         OP_INSERT: begin
            if (full_now) begin
               status = ST_FULL;
            end else if (ins_rng) begin
               do_ins   = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end else begin
               status = ST_BADPOS;
            end
         end
         default: begin
            if (count_ff == '0) begin
               status = ST_EMPTY;
            end else if (in_rng) begin
               do_del   = 1'b1;
               count_in = count_ff - CNT_W'(1);
            end else begin
               status = ST_BADPOS;
            end
         end
      endcase
   end

   // One cell per entry: each compares its index with the position
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam logic [POS_W:0] CI = (POS_W + 1)'(i);
      logic [DATA_W-1:0] below, above;

      if (i > 0) begin : g_below
         assign below = store_ff[i-1];
      end else begin : g_below0
         assign below = '0;
      end

      if (i < DEPTH - 1) begin : g_above
         assign above = store_ff[i+1];
      end else begin : g_above0
         assign above = '0;
      end

      always_comb begin
         store_in[i] = store_ff[i];
         if (do_ins) begin
            if (CI == p0)                    store_in[i] = req_ff.value;
            else if (CI > p0 && CI <= cnt9)  store_in[i] = below;
         end else if (do_del) begin
            if (CI >= p0 && CI + (POS_W + 1)'(1) < cnt9) store_in[i] = above;
         end else if (do_rep) begin
            if (CI == p0) store_in[i] = req_ff.value;
         end
      end
   end

   // Update cells on execute
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         for (int k = 0; k < DEPTH; k++) store_ff[k] <= store_in[k];
      end
   end

   // Result fields after the operation
   always_comb begin
      rsp_in.ok         = (status == ST_DONE);
      rsp_in.status     = status;
      rsp_in.read_value = rd;
      rsp_in.count      = count_in;
      rsp_in.empty_flag = (count_in == '0);
      rsp_in.full_flag  = (count_in >= cap_use);
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) rsp_ff <= rsp_in;
   end

   // Element count
   always_ff @(posedge clock) begin
      if (reset)         count_ff <= '0;
      else if (cmd.exec) count_ff <= count_in;
   end

   assign rsp_payload = rsp_ff;

endmodule

[rtl/core/positional_array_list.sv]
// Top level of the positional array list: capacity register on the APB-style
// port, controller and datapath. Depends on pal_pkg, pal_ctrl and pal_dpath.
//
// Usage:
//   A transaction is taken at a rising edge where start is high and busy is
//   low; req_payload carries opcode, 1-based position and value. Opcodes are
//   read, replace, insert (later elements move up) and delete (later
//   elements move down).
//   Exactly one result follows: rsp_strobe is registered from the execute
//   state and stays high for one cycle, together with the registered result,
//   which is taken while rsp_strobe is high. The receiver has no way to stall.
//   busy is high for the one execute cycle after acceptance, so a new
//   transaction is not taken until the last one has executed; the shift of
//   all cells completes in that execute cycle.
//   The capacity register sits at byte address 0 and may be written only
//   while no transaction is in flight; it is saturated to 1..16 in use.
//   Reset (synchronous) empties the list and sets the capacity to 16; the
//   cell contents are left as they were and only become visible once
//   written again.
module positional_array_list
   import pal_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_type            req_payload,
   output logic               rsp_strobe,
   output rsp_type            rsp_payload,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready
);

   ctrl_cmd_type     cmd;
   logic [CAP_W-1:0] capacity_ff, capacity_in;
   logic [CNT_W-1:0] cap_use;
   logic             reg_sel;

   assign pready  = 1'b1;
   assign reg_sel = (paddr[PADDR_W-1:2] == REG_CAPACITY);

   // Capacity register write
   always_comb begin
      capacity_in = capacity_ff;
      if (psel && penable && pwrite && pready && reg_sel) capacity_in = pwdata[CAP_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) capacity_ff <= CAPACITY_RESET;
      else       capacity_ff <= capacity_in;
   end

   // Register read back
   assign prdata = reg_sel ? PDATA_W'(capacity_ff) : '0;

   // Saturate the capacity in use to 1..DEPTH
   always_comb begin
      if (capacity_ff == '0)
         cap_use = CNT_W'(1);
      else if ((CNT_W + CAP_W)'(capacity_ff) > (CNT_W + CAP_W)'(DEPTH))
         cap_use = CNT_W'(DEPTH);
      else
         cap_use = CNT_W'(capacity_ff);
   end

   pal_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .cmd        (cmd),
      .rsp_strobe (rsp_strobe)
   );

   pal_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .cap_use     (cap_use),
      .rsp_payload (rsp_payload)
   );

endmodule
